/* rtl/q8bd_pkg.sv */
// ----------------------------------------------------------------------------
// q8bd_pkg: shared types and constants of the Q8_0 group dequantizer
// Scale decode result and binary32 special patterns.
// ----------------------------------------------------------------------------
package q8bd_pkg;

  localparam int WEIGHT_W = 8;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 4;
  localparam int HALF_W   = 16;
  localparam int MANT_W   = 11;

  localparam logic [VALUE_W-1:0] F32_QNAN = 32'h7FC0_0000;
  localparam logic [VALUE_W-1:0] F32_INF  = 32'h7F80_0000;
  localparam logic [4:0]         HEXP_MAX = 5'h1F;

  // decoded scale shared by all lanes
  typedef struct packed {
    logic        sign;
    logic        is_nan;
    logic        is_inf;
    logic [10:0] mant;    // significand with hidden bit
    logic [8:0]  ebias;   // e2 + 127, always positive (103..133)
  } scale_t;

endpackage

/* rtl/q8bd_scale_dec.sv */
// ----------------------------------------------------------------------------
// q8bd_scale_dec: binary16 scale decode
// Splits the half into sign, significand and biased exponent offset.
// ----------------------------------------------------------------------------
module q8bd_scale_dec (
  input  logic [q8bd_pkg::HALF_W-1:0] half_i,
  output q8bd_pkg::scale_t            scale_o
);

  logic [4:0] he;
  logic [9:0] hm;

  assign he = half_i[14:10];
  assign hm = half_i[9:0];

  always_comb begin
    scale_o.sign   = half_i[15];
    scale_o.is_nan = (he == q8bd_pkg::HEXP_MAX) && (hm != 10'd0);
    scale_o.is_inf = (he == q8bd_pkg::HEXP_MAX) && (hm == 10'd0);
    if (he == 5'd0) begin
      scale_o.mant  = {1'b0, hm};
      scale_o.ebias = 9'd103;               // -24 + 127
    end else begin
      scale_o.mant  = {1'b1, hm};
      scale_o.ebias = 9'd102 + {4'd0, he};  // he - 25 + 127
    end
  end

endmodule

/* rtl/q8bd_lane.sv */
// ----------------------------------------------------------------------------
// q8bd_lane: one weight times the decoded scale
// 11x8 magnitude product, leading-one position, binary32 packing.
// ----------------------------------------------------------------------------
module q8bd_lane (
  input  q8bd_pkg::scale_t               scale_i,
  input  logic [q8bd_pkg::WEIGHT_W-1:0]  weight_i,
  input  logic                           en_i,
  output logic [q8bd_pkg::VALUE_W-1:0]   value_o
);

  logic        wneg;
  logic [7:0]  wmag;
  logic [18:0] prod;
  logic [4:0]  lead;
  logic [8:0]  bexp;
  logic [41:0] shifted;
  logic        sign;

  assign wneg = weight_i[7];
  assign wmag = wneg ? (8'd0 - weight_i) : weight_i;  // -128 gives 0x80
  assign prod = scale_i.mant * {3'd0, wmag};
  assign sign = scale_i.sign ^ wneg;

  always_comb begin
    lead = 5'd0;
    for (int i = 0; i < 19; i++) begin
      if (prod[i]) lead = 5'(i);
    end
  end

  assign bexp    = scale_i.ebias + {4'd0, lead};
  assign shifted = {23'd0, prod} << (5'd23 - lead);

  always_comb begin
    if (!en_i) begin
      value_o = '0;
    end else if (scale_i.is_nan || (scale_i.is_inf && wmag == 8'd0)) begin
      value_o = q8bd_pkg::F32_QNAN;
    end else if (scale_i.is_inf) begin
      value_o = {sign, q8bd_pkg::F32_INF[30:0]};
    end else if (prod == 19'd0) begin
      value_o = {sign, 31'd0};
    end else begin
      value_o = {sign, bexp[7:0], shifted[22:0]};
    end
  end

endmodule

/* rtl/q8bd_out_buf.sv */
// ----------------------------------------------------------------------------
// q8bd_out_buf: output register with a skid stage
// Full-rate output register plus a skid register so ready is registered.
// ----------------------------------------------------------------------------
module q8bd_out_buf #(
  parameter int W = 260
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         s_valid,
  output logic         s_ready,
  input  logic [W-1:0] s_data,
  output logic         m_valid,
  input  logic         m_ready,
  output logic [W-1:0] m_data
);

  logic         out_vld_r, skid_vld_r;
  logic [W-1:0] out_dat_r, skid_dat_r;

  assign s_ready = !skid_vld_r;
  assign m_valid = out_vld_r;
  assign m_data  = out_dat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      if (!out_vld_r || m_ready) begin
        if (skid_vld_r) begin
          out_vld_r  <= 1'b1;
          skid_vld_r <= 1'b0;
        end else begin
          out_vld_r <= s_valid;
        end
      end else if (s_valid && s_ready) begin
        skid_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || m_ready) begin
      out_dat_r <= skid_vld_r ? skid_dat_r : s_data;
    end
    if (s_valid && s_ready && out_vld_r && !m_ready) begin
      skid_dat_r <= s_data;
    end
  end

endmodule

/* rtl/q8_block_dequantizer_unit.sv */
// ----------------------------------------------------------------------------
// q8_block_dequantizer_unit: Q8_0 group dequantizer
// Eight signed weights times a binary16 scale, binary32 results per lane.
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (low bit first)
// in_     | in  | scale_half[15:0], weight_0..weight_LANES-1 (8b each), valid_count[3:0]
// out_    | out | value_0..value_LANES-1 (32b each), count_out[3:0]
// One word per cycle sustained while out_tready is high; an accepted word is registered
// in the output register. Lanes are combinational from the input word to that register.
// A skid register holds one word during an output stall; in_tready drops
// only when both are full. Reset (rst_n low) empties both registers.
// ----------------------------------------------------------------------------
module q8_block_dequantizer_unit #(
  parameter int LANES = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // scale_half, weight_0.., valid_count, zero pad
  input  logic [((16+8*LANES+4+7)/8)*8-1:0]      in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // value_0.., count_out, zero pad
  output logic [((32*LANES+4+7)/8)*8-1:0]        out_tdata
);

  localparam int OUT_W = ((32 * LANES + 4 + 7) / 8) * 8;
  localparam int CNT_LO = 16 + 8*LANES;

  q8bd_pkg::scale_t        scale;
  logic [3:0]              count;
  logic [32*LANES-1:0]     lanes_val;
  logic [OUT_W-1:0]        merged;

  assign count = in_tdata[CNT_LO +: 4];

  q8bd_scale_dec u_dec (
    .half_i  (in_tdata[15:0]),
    .scale_o (scale)
  );

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    q8bd_lane u_lane (
      .scale_i  (scale),
      .weight_i (in_tdata[16 + 8*g +: 8]),
      .en_i     ({1'b0, count} > 5'(g)),
      .value_o  (lanes_val[32*g +: 32])
    );
  end

  assign merged = OUT_W'({count, lanes_val});

  q8bd_out_buf #(.W(OUT_W)) u_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .s_data  (merged),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_data  (out_tdata)
  );

`ifndef SYNTHESIS
  a_ready_after_reset: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> in_tready) else $error("ready low after reset");
  a_out_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !out_tvalid) |=> out_tvalid)
    else $error("accepted word lost");
  a_no_valid_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid) else $error("valid after reset");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("output changed during stall");
`endif

endmodule
